// ===== rtl/ascii_integer_parser_defines.svh =====
// Assertion helpers used by the checker file
`ifndef ASCII_INTEGER_PARSER_DEFINES_SVH
`define ASCII_INTEGER_PARSER_DEFINES_SVH

// Consequent checked on the same edge as the antecedent
`define AIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aip_checker: property failed");

// Consequent checked on the edge after the antecedent
`define AIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aip_checker: property failed");

`endif

// ===== rtl/aip_pkg.sv =====
package aip_pkg;

    // Field widths
    localparam int VALUE_WIDTH  = 32;
    localparam int OFFSET_WIDTH = 16;
    localparam int CH_W         = 8;
    localparam int BASE_W       = 5;
    localparam int DIGIT_W      = 4;

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_SP    = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LF_HI = 8'h66;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;

    // Bases
    localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
    localparam logic [BASE_W-1:0] BASE_8    = 5'd8;
    localparam logic [BASE_W-1:0] BASE_10   = 5'd10;
    localparam logic [BASE_W-1:0] BASE_16   = 5'd16;

    // Parse phase
    typedef enum logic [3:0] {
        PH_SPACE  = 4'b0001,
        PH_SIGNED = 4'b0010,
        PH_ZERO   = 4'b0100,
        PH_DIGITS = 4'b1000
    } t_phase;

    // Classified character, front to back
    typedef struct packed {
        logic               first;
        logic               is_ws;
        logic               is_sign;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               dig_ok;
        logic [DIGIT_W-1:0] dig;
    } t_cls;

endpackage

// ===== rtl/aip_in_if.sv =====
interface aip_in_if;
    logic                      valid;
    logic                      ready;
    logic [aip_pkg::CH_W-1:0]  ch;
    logic                      first;

    modport source (output valid, output ch, output first, input ready);
    modport sink   (input valid, input ch, input first, output ready);
endinterface

// ===== rtl/aip_out_if.sv =====
interface aip_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [aip_pkg::VALUE_WIDTH-1:0]  value;
    logic                                    done_res;
    logic [aip_pkg::OFFSET_WIDTH-1:0]        end_offset;

    modport source (output valid, output value, output done_res, output end_offset,
                    input ready);
    modport sink   (input valid, input value, input done_res, input end_offset,
                    output ready);
endinterface

// ===== rtl/aip_cfg_if.sv =====
interface aip_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [aip_pkg::BASE_W-1:0]  base_select;

    modport source (output valid, output base_select, input ready);
    modport sink   (input valid, input base_select, output ready);
endinterface

// ===== rtl/aip_front.sv =====
module aip_front (
    aip_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output aip_pkg::t_cls   o_cls
);

    // Take an item whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Character classes and digit value
    always_comb begin
        o_cls          = '0;
        o_cls.first    = i_in.first;
        o_cls.is_ws    = (i_in.ch == aip_pkg::CH_SP) || (i_in.ch == aip_pkg::CH_TAB)
                      || (i_in.ch == aip_pkg::CH_LF);
        o_cls.is_minus = (i_in.ch == aip_pkg::CH_MINUS);
        o_cls.is_sign  = o_cls.is_minus || (i_in.ch == aip_pkg::CH_PLUS);
        o_cls.is_zero  = (i_in.ch == aip_pkg::CH_0);
        o_cls.is_x     = (i_in.ch == aip_pkg::CH_LX) || (i_in.ch == aip_pkg::CH_UX);
        if (i_in.ch >= aip_pkg::CH_0 && i_in.ch <= aip_pkg::CH_9) begin
            o_cls.dig_ok = 1'b1;
            o_cls.dig    = aip_pkg::DIGIT_W'(i_in.ch - aip_pkg::CH_0);
        end else if (i_in.ch >= aip_pkg::CH_LA && i_in.ch <= aip_pkg::CH_LF_HI) begin
            o_cls.dig_ok = 1'b1;
            o_cls.dig    = aip_pkg::DIGIT_W'(i_in.ch - aip_pkg::CH_LA + 8'd10);
        end else if (i_in.ch >= aip_pkg::CH_UA && i_in.ch <= aip_pkg::CH_UF) begin
            o_cls.dig_ok = 1'b1;
            o_cls.dig    = aip_pkg::DIGIT_W'(i_in.ch - aip_pkg::CH_UA + 8'd10);
        end
    end

endmodule

// ===== rtl/aip_queue.sv =====
module aip_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  aip_pkg::t_cls   i_push_data,
    output logic            o_full,
    output logic            o_valid,
    output aip_pkg::t_cls   o_data,
    input  logic            i_pop
);

    aip_pkg::t_cls r_mem [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count
    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/aip_back.sv =====
module aip_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [aip_pkg::BASE_W-1:0]    i_base_select,
    input  logic                          i_q_valid,
    input  aip_pkg::t_cls                 i_q_data,
    output logic                          o_pop,
    aip_out_if.source                     o_out
);

    // Parse state
    aip_pkg::t_phase                    r_phase, n_phase;
    logic                               r_neg, n_neg;
    logic [aip_pkg::BASE_W-1:0]         r_base, n_base;
    logic [aip_pkg::VALUE_WIDTH-1:0]    r_acc, n_acc;
    logic [aip_pkg::OFFSET_WIDTH-1:0]   r_pos, n_pos;
    logic                               r_fin, n_fin;

    // Output register
    logic                               r_out_valid, n_out_valid;
    logic                               r_out_neg;
    logic [aip_pkg::VALUE_WIDTH-1:0]    r_out_acc;
    logic                               r_out_done;
    logic [aip_pkg::OFFSET_WIDTH-1:0]   r_out_pos;

    // State after an optional clear on a new string
    aip_pkg::t_phase                    e_phase;
    logic                               e_neg;
    logic [aip_pkg::BASE_W-1:0]         e_base;
    logic [aip_pkg::VALUE_WIDTH-1:0]    e_acc;
    logic [aip_pkg::OFFSET_WIDTH-1:0]   e_pos;
    logic                               e_fin;

    logic                               tk_prefix;
    logic                               tk_digit;
    logic                               adv;
    logic                               auto_base;
    logic [aip_pkg::BASE_W-1:0]         dbase;
    logic [aip_pkg::VALUE_WIDTH-1:0]    prod;

    assign o_pop       = i_q_valid && (!r_out_valid || o_out.ready);
    assign auto_base   = (i_base_select == aip_pkg::BASE_AUTO);

    // One character of the parse
    always_comb begin
        e_phase   = i_q_data.first ? aip_pkg::PH_SPACE : r_phase;
        e_neg     = i_q_data.first ? 1'b0 : r_neg;
        e_base    = i_q_data.first ? '0 : r_base;
        e_acc     = i_q_data.first ? '0 : r_acc;
        e_pos     = i_q_data.first ? '0 : r_pos;
        e_fin     = i_q_data.first ? 1'b0 : r_fin;

        n_phase   = e_phase;
        n_neg     = e_neg;
        n_base    = e_base;
        n_acc     = e_acc;
        n_pos     = e_pos;
        n_fin     = e_fin;

        tk_prefix = 1'b0;
        tk_digit  = 1'b0;
        adv       = 1'b0;
        dbase     = e_base;

        if (!e_fin) begin
            case (e_phase)
                aip_pkg::PH_SPACE: begin
                    if (i_q_data.is_ws) begin
                        adv = 1'b1;
                    end else if (i_q_data.is_sign) begin
                        n_neg   = i_q_data.is_minus;
                        n_phase = aip_pkg::PH_SIGNED;
                        adv     = 1'b1;
                    end else begin
                        tk_prefix = 1'b1;
                    end
                end
                aip_pkg::PH_SIGNED: begin
                    tk_prefix = 1'b1;
                end
                aip_pkg::PH_ZERO: begin
                    if (i_q_data.is_x) begin
                        n_base  = aip_pkg::BASE_16;
                        n_phase = aip_pkg::PH_DIGITS;
                        adv     = 1'b1;
                    end else begin
                        tk_digit = 1'b1;
                    end
                end
                default: begin
                    tk_digit = 1'b1;
                end
            endcase
        end

        // Leading zero may open an octal or hex prefix
        if (tk_prefix) begin
            if (i_q_data.is_zero && (auto_base || i_base_select == aip_pkg::BASE_16)) begin
                n_base  = auto_base ? aip_pkg::BASE_8 : aip_pkg::BASE_16;
                n_acc   = '0;
                n_phase = aip_pkg::PH_ZERO;
                adv     = 1'b1;
            end else begin
                dbase    = auto_base ? aip_pkg::BASE_10 : i_base_select;
                n_base   = dbase;
                tk_digit = 1'b1;
            end
        end

        // Multiply-add, wrapping at the value width
        prod = e_acc * {{(aip_pkg::VALUE_WIDTH-aip_pkg::BASE_W){1'b0}}, dbase};
        if (tk_digit) begin
            if (!i_q_data.dig_ok || ({1'b0, i_q_data.dig} >= dbase)) begin
                n_fin = 1'b1;
            end else begin
                n_acc   = prod + {{(aip_pkg::VALUE_WIDTH-aip_pkg::DIGIT_W){1'b0}},
                                  i_q_data.dig};
                n_phase = aip_pkg::PH_DIGITS;
                adv     = 1'b1;
            end
        end

        // Offset saturates
        if (adv && (e_pos != '1)) begin
            n_pos = e_pos + 1'b1;
        end
    end

    always_comb begin
        n_out_valid = o_pop || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= aip_pkg::PH_SPACE;
            r_neg       <= 1'b0;
            r_base      <= '0;
            r_acc       <= '0;
            r_pos       <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_base  <= n_base;
                r_acc   <= n_acc;
                r_pos   <= n_pos;
                r_fin   <= n_fin;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_neg  <= n_neg;
            r_out_acc  <= n_acc;
            r_out_done <= n_fin;
            r_out_pos  <= n_pos;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.value      = $signed(r_out_neg ? ('0 - r_out_acc) : r_out_acc);
    assign o_out.done_res   = r_out_done;
    assign o_out.end_offset = r_out_pos;

endmodule

// ===== rtl/ascii_integer_parser.sv =====
// Streaming signed integer parser, one character per item.
// Input channel i_in carries ch and first; first starts a new string and
// clears the parse state before that character is handled. Leading blanks,
// an optional sign, an optional 0/0x prefix and digits are taken; a NUL or
// the first unaccepted character ends the parse.
// Output channel o_out gives one item per input item: the signed value so
// far, done_res and end_offset. Later items of a finished string repeat it.
// Configuration channel i_cfg writes base_select (0 detects the base).
// Throughput is one item per cycle while o_out is not stalled; the multiply-add
// on the accumulator in the back end is combinational. An accepted item is
// written to the two-entry classify queue, and its result is loaded into the
// output register when the back end pops it, which raises o_out.valid.
// When o_out stalls, the output register holds and the queue absorbs up to
// two more items before i_in.ready drops.
// Reset (synchronous, active low) sets base_select to 0, empties the queue
// and returns the parser to blank skipping with zero value and offset.
module ascii_integer_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aip_in_if.sink      i_in,
    aip_out_if.source   o_out,
    aip_cfg_if.sink     i_cfg
);

    logic [aip_pkg::BASE_W-1:0] r_base_select;
    logic                       push;
    logic                       full;
    logic                       q_valid;
    logic                       pop;
    aip_pkg::t_cls              push_data;
    aip_pkg::t_cls              q_data;

    // Base register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_select <= aip_pkg::BASE_AUTO;
        end else if (i_cfg.valid) begin
            r_base_select <= i_cfg.base_select;
        end
    end

    aip_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cls  (push_data)
    );

    aip_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (pop)
    );

    aip_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_base_select (r_base_select),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_pop         (pop),
        .o_out         (o_out)
    );

endmodule

// ===== rtl/aip_checker.sv =====
`include "ascii_integer_parser_defines.svh"

module aip_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [aip_pkg::VALUE_WIDTH-1:0] i_out_value,
    input  logic                                 i_out_done_res,
    input  logic [aip_pkg::OFFSET_WIDTH-1:0]     i_out_end_offset
);

    // Items accepted but not yet delivered
    logic [2:0] r_outst, n_outst;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_outst = r_outst + 3'(in_acc) - 3'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= 3'd0;
        end else begin
            r_outst <= n_outst;
        end
    end

    // A stalled result holds its place
    `AIP_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_value) && $stable(i_out_done_res) &&
        $stable(i_out_end_offset))

    // No result without an item in flight
    `AIP_ASSERT_NOW(a_no_invent, i_clk, i_rst_n, i_out_valid, r_outst != 3'd0)

    // At most queue plus output register in flight
    `AIP_ASSERT_NOW(a_bound, i_clk, i_rst_n, 1'b1, r_outst <= 3'd3)

    // Input only backs up once the queue is full
    `AIP_ASSERT_NOW(a_ready_full, i_clk, i_rst_n, !i_in_ready, r_outst >= 3'd2)

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_value      (o_out.value),
    .i_out_done_res   (o_out.done_res),
    .i_out_end_offset (o_out.end_offset)
);

// ===== dv/tb_ascii_integer_parser.sv =====
`timescale 1ns / 100ps

module tb_ascii_integer_parser;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 1250;
    localparam int NO_DIGIT     = 255;

    localparam logic [aip_pkg::BASE_W-1:0] BASE_UNARY = 5'd1;
    localparam logic [aip_pkg::BASE_W-1:0] BASE_TOP   = 5'd31;
    // first letter past the hex digits
    localparam logic [aip_pkg::CH_W-1:0]   CH_LG      = aip_pkg::CH_LF_HI + 8'd1;
    localparam logic [aip_pkg::CH_W-1:0]   BLANKS [3] =
        '{aip_pkg::CH_SP, aip_pkg::CH_TAB, aip_pkg::CH_LF};

    typedef logic [aip_pkg::CH_W-1:0] t_char_q[$];

    typedef struct {
        logic signed [aip_pkg::VALUE_WIDTH-1:0] value;
        logic                                   done_res;
        logic [aip_pkg::OFFSET_WIDTH-1:0]       end_offset;
    } t_parse_result;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    aip_in_if  in_if ();
    aip_out_if out_if ();
    aip_cfg_if cfg_if ();

    ascii_integer_parser i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #HALF_PERIOD clk = ~clk;

    int errors       = 0;
    int items_sent   = 0;
    int src_idle_pct = 6;
    int snk_idle_pct = 86;
    int stall_cycles = 0;

    t_parse_result parse_results_due[$];

    // Parser state as the block should hold it
    logic [aip_pkg::BASE_W-1:0]       base_reg;
    aip_pkg::t_phase                  ps_phase;
    logic                             ps_neg;
    logic [aip_pkg::BASE_W-1:0]       ps_base;
    logic [aip_pkg::VALUE_WIDTH-1:0]  ps_acc;
    logic [aip_pkg::OFFSET_WIDTH-1:0] ps_pos;
    logic                             ps_done;

    function automatic void parse_clear();
        ps_phase = aip_pkg::PH_SPACE;
        ps_neg   = 1'b0;
        ps_base  = '0;
        ps_acc   = '0;
        ps_pos   = '0;
        ps_done  = 1'b0;
    endfunction

    // offset sticks at its top value
    function automatic void parse_bump();
        if (ps_pos != '1)
            ps_pos = ps_pos + 1'b1;
    endfunction

    function automatic int digit_weight(input logic [aip_pkg::CH_W-1:0] c);
        if (c >= aip_pkg::CH_0 && c <= aip_pkg::CH_9)
            return int'(c - aip_pkg::CH_0);
        if (c >= aip_pkg::CH_LA && c <= aip_pkg::CH_LF_HI)
            return int'(c - aip_pkg::CH_LA) + 10;
        if (c >= aip_pkg::CH_UA && c <= aip_pkg::CH_UF)
            return int'(c - aip_pkg::CH_UA) + 10;
        return NO_DIGIT;
    endfunction

    function automatic void parse_digit(input logic [aip_pkg::CH_W-1:0] c);
        int w;
        w = digit_weight(c);
        if (w == NO_DIGIT || w >= int'(ps_base)) begin
            ps_done = 1'b1;
        end else begin
            ps_acc   = ps_acc * aip_pkg::VALUE_WIDTH'(ps_base) + aip_pkg::VALUE_WIDTH'(w);
            ps_phase = aip_pkg::PH_DIGITS;
            parse_bump();
        end
    endfunction

    // character where a 0 / 0x prefix may start
    function automatic void parse_prefix(input logic [aip_pkg::CH_W-1:0] c);
        if (c == aip_pkg::CH_0 &&
            (base_reg == aip_pkg::BASE_AUTO || base_reg == aip_pkg::BASE_16)) begin
            ps_base  = (base_reg == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_8 : aip_pkg::BASE_16;
            ps_acc   = '0;
            ps_phase = aip_pkg::PH_ZERO;
            parse_bump();
        end else begin
            ps_base = (base_reg == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_10 : base_reg;
            parse_digit(c);
        end
    endfunction

    function automatic t_parse_result next_parse_result(input logic [aip_pkg::CH_W-1:0] c,
                                                        input logic f);
        t_parse_result r;
        if (f)
            parse_clear();
        if (!ps_done) begin
            case (ps_phase)
                aip_pkg::PH_SPACE: begin
                    if (c == aip_pkg::CH_SP || c == aip_pkg::CH_TAB ||
                        c == aip_pkg::CH_LF) begin
                        parse_bump();
                    end else if (c == aip_pkg::CH_MINUS || c == aip_pkg::CH_PLUS) begin
                        ps_neg   = (c == aip_pkg::CH_MINUS);
                        ps_phase = aip_pkg::PH_SIGNED;
                        parse_bump();
                    end else begin
                        parse_prefix(c);
                    end
                end
                aip_pkg::PH_SIGNED: parse_prefix(c);
                aip_pkg::PH_ZERO: begin
                    if (c == aip_pkg::CH_LX || c == aip_pkg::CH_UX) begin
                        ps_base  = aip_pkg::BASE_16;
                        ps_phase = aip_pkg::PH_DIGITS;
                        parse_bump();
                    end else begin
                        parse_digit(c);
                    end
                end
                default: parse_digit(c);
            endcase
        end
        r.value      = ps_neg ? (aip_pkg::VALUE_WIDTH'(0) - ps_acc) : ps_acc;
        r.done_res   = ps_done;
        r.end_offset = ps_pos;
        return r;
    endfunction

    function automatic logic [aip_pkg::CH_W-1:0] dig_char(input int v, input bit upper);
        if (v < 10)
            return aip_pkg::CH_0 + aip_pkg::CH_W'(v);
        return (upper ? aip_pkg::CH_UA : aip_pkg::CH_LA) + aip_pkg::CH_W'(v - 10);
    endfunction

    // Present one character; valid is left high for the next item
    task automatic send_char(input logic [aip_pkg::CH_W-1:0] c, input logic f);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.ch    <= c;
        in_if.first <= f;
        do @(posedge clk); while (!in_if.ready);
        parse_results_due.push_back(next_parse_result(c, f));
        items_sent++;
    endtask

    task automatic send_string(input t_char_q s, input logic f);
        foreach (s[i])
            send_char(s[i], f && (i == 0));
    endtask

    // Hold off the sender until every result has come back
    task automatic wait_drained();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (parse_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [aip_pkg::BASE_W-1:0] b);
        wait_drained();
        @(negedge clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.base_select <= b;
        do @(posedge clk); while (!cfg_if.ready);
        base_reg = b;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // First string straight after reset carries no flag; trailing item is ignored
    task automatic test_unflagged_start();
        send_string('{aip_pkg::CH_SP, aip_pkg::CH_MINUS, dig_char(1, 0), dig_char(7, 0),
                      aip_pkg::CH_NUL, dig_char(5, 0)}, 1'b0);
    endtask

    task automatic test_prefix_and_sign();
        // hex prefix with no digits after it
        send_string('{aip_pkg::CH_LF, aip_pkg::CH_PLUS, aip_pkg::CH_0, aip_pkg::CH_LX,
                      CH_LG}, 1'b1);
        // blank after the sign ends the parse
        send_string('{aip_pkg::CH_MINUS, aip_pkg::CH_SP, dig_char(3, 0)}, 1'b1);
        // octal, stopped by a 9
        send_string('{aip_pkg::CH_TAB, aip_pkg::CH_0, dig_char(7, 0), dig_char(9, 0)},
                    1'b1);
        send_string('{8'hFF}, 1'b1);
    endtask

    task automatic test_base_extremes();
        write_base(BASE_UNARY);
        send_string('{aip_pkg::CH_0, dig_char(1, 0)}, 1'b1);
        write_base(BASE_TOP);
        send_string('{dig_char(15, 0), dig_char(15, 1), aip_pkg::CH_NUL}, 1'b1);
        write_base(aip_pkg::BASE_16);
        send_string('{aip_pkg::CH_0, aip_pkg::CH_UX, dig_char(10, 1)}, 1'b1);
        write_base(aip_pkg::BASE_AUTO);
    endtask

    // Mostly well-formed numbers with random content, some noise and damage
    task automatic test_random_strings(input int n);
        t_char_q                    s;
        int                         stop_at;
        int                         strings;
        int                         eb;
        int                         lo;
        int                         n_dig;
        logic [aip_pkg::BASE_W-1:0] b;
        stop_at = items_sent + n;
        strings = 0;
        while (items_sent < stop_at) begin
            if (strings % 16 == 0) begin
                case ($urandom_range(0, 5))
                    0, 1:    b = aip_pkg::BASE_AUTO;
                    2:       b = aip_pkg::BASE_10;
                    3:       b = aip_pkg::BASE_16;
                    4:       b = aip_pkg::BASE_W'($urandom_range(17, 31));
                    default: b = aip_pkg::BASE_W'($urandom_range(0, 31));
                endcase
                write_base(b);
            end
            s = {};
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8))
                    s.push_back(aip_pkg::CH_W'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(0, 3)) s.push_back(BLANKS[$urandom_range(0, 2)]);
                case ($urandom_range(0, 2))
                    0:       s.push_back(aip_pkg::CH_MINUS);
                    1:       s.push_back(aip_pkg::CH_PLUS);
                    default: ;
                endcase
                // base the digits are drawn from; letters stop at f
                eb = (base_reg > aip_pkg::BASE_16) ? 16 : int'(base_reg);
                lo = 0;
                if (base_reg == aip_pkg::BASE_AUTO || base_reg == aip_pkg::BASE_16) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            s.push_back(aip_pkg::CH_0);
                            s.push_back($urandom_range(0, 1) ? aip_pkg::CH_LX
                                                             : aip_pkg::CH_UX);
                            eb = 16;
                        end
                        1: if (base_reg == aip_pkg::BASE_AUTO) begin
                            s.push_back(aip_pkg::CH_0);
                            eb = 8;
                        end
                        default: if (base_reg == aip_pkg::BASE_AUTO) begin
                            eb = 10;
                            lo = 1;
                        end
                    endcase
                end
                // long runs now and then, to wrap the accumulator
                n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(0, 8);
                for (int i = 0; i < n_dig; i++)
                    s.push_back(dig_char($urandom_range((i == 0) ? lo : 0, eb - 1),
                                         $urandom_range(0, 1)));
                case ($urandom_range(0, 5))
                    0, 1, 2: s.push_back(aip_pkg::CH_NUL);
                    3:       s.push_back(aip_pkg::CH_W'($urandom_range(0, 255)));
                    4: begin
                        s.push_back(aip_pkg::CH_NUL);
                        repeat ($urandom_range(1, 3))
                            s.push_back(aip_pkg::CH_W'($urandom_range(0, 255)));
                    end
                    default: ;
                endcase
                // damage one character of the odd string
                if (s.size() > 0 && $urandom_range(0, 9) == 0)
                    s[$urandom_range(0, s.size() - 1)] =
                        aip_pkg::CH_W'($urandom_range(0, 255));
            end
            // a few strings run on without a flag
            send_string(s, $urandom_range(0, 19) != 0);
            strings++;
        end
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    // Compare each result item with the oldest one due
    always @(posedge clk) begin : check_results
        t_parse_result want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (parse_results_due.size() == 0) begin
                $error("result item with none due: value %0d", out_if.value);
                errors++;
            end else begin
                want = parse_results_due.pop_front();
                if (out_if.value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, out_if.value);
                    errors++;
                end
                if (out_if.done_res !== want.done_res) begin
                    $error("done_res: expected %0b, got %0b", want.done_res, out_if.done_res);
                    errors++;
                end
                if (out_if.end_offset !== want.end_offset) begin
                    $error("end_offset: expected %0d, got %0d", want.end_offset,
                           out_if.end_offset);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("tb_ascii_integer_parser: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        in_if.valid        = 1'b0;
        in_if.ch           = aip_pkg::CH_NUL;
        in_if.first        = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.base_select = aip_pkg::BASE_AUTO;
        out_if.ready       = 1'b0;
        base_reg           = aip_pkg::BASE_AUTO;
        parse_clear();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unflagged_start();
        test_prefix_and_sign();
        test_base_extremes();
        test_random_strings(RANDOM_ITEMS / 3);

        wait_drained();
        src_idle_pct = 86;
        snk_idle_pct = 6;
        test_random_strings(RANDOM_ITEMS / 3);

        wait_drained();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_strings(RANDOM_ITEMS / 3);

        wait_drained();
        if (errors == 0 && parse_results_due.size() == 0)
            $display("tb_ascii_integer_parser: done, clean");
        else
            $display("tb_ascii_integer_parser: done, errors");
        $finish;
    end

endmodule
